FILE: rtl/xrd_pkg.sv
// Shared types and constants of the xorshift128+ ranged draw block.
package xrd_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned WarmW = 4;
  localparam int unsigned CfgIdxW = 2;

  // Generator shift amounts
  localparam int unsigned ShlA = 23;
  localparam int unsigned ShrA = 18;
  localparam int unsigned ShrB = 5;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_FIRST_SEED = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_SEED = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WARMUP = 2'd2;

  // Register reset values
  localparam logic [WordW-1:0] FIRST_SEED_RST = 64'd1;
  localparam logic [WordW-1:0] SECOND_SEED_RST = 64'd2;
  localparam logic [WarmW-1:0] WARMUP_RST = 4'd10;

  // Command codes
  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Depth of the queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  // Divider step counter
  localparam int unsigned DivCntW = $clog2(WordW);

  typedef enum logic {
    FR_IDLE,
    FR_WARM
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

  // One draw handed from front to back
  typedef struct packed {
    logic [WordW-1:0] sum;
    logic [WordW-1:0] lo;
    logic [WordW-1:0] span;
    logic             zero;
  } job_t;

  // Queue status seen by a producer or consumer
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

FILE: rtl/xrd_front.sv
// Front part: configuration registers, generator state, command handling.
module xrd_front
  import xrd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [WordW-1:0]         cfg_data_i,
  input  logic                     push,
  output logic                     full,
  input  logic                     command_i,
  input  logic signed [WordW-1:0]  low_bound_i,
  input  logic signed [WordW-1:0]  high_bound_i,
  input  q_status_t                q_status_i,
  output logic                     q_push_o,
  output job_t                     q_job_o
);

  front_state_e state_q, state_d;
  logic [WordW-1:0] word_a_q, word_a_d;
  logic [WordW-1:0] word_b_q, word_b_d;
  logic [WarmW-1:0] cnt_q, cnt_d;
  logic [WordW-1:0] first_seed_q, second_seed_q;
  logic [WarmW-1:0] warmup_q;

  logic             accept;
  logic [WordW-1:0] sum, t, next_b, span;

  // Hold configuration; users must write only while the block is idle (not enforced)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_seed_q  <= FIRST_SEED_RST;
      second_seed_q <= SECOND_SEED_RST;
      warmup_q      <= WARMUP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIRST_SEED:  first_seed_q  <= cfg_data_i;
        CFG_SECOND_SEED: second_seed_q <= cfg_data_i;
        CFG_WARMUP:      warmup_q      <= cfg_data_i[WarmW-1:0];
        default: ;
      endcase
    end
  end

  // One generator advance
  always_comb begin
    sum    = word_a_q + word_b_q;
    t      = word_a_q ^ (word_a_q << ShlA);
    next_b = t ^ word_b_q ^ (t >> ShrA) ^ (word_b_q >> ShrB);
    span   = high_bound_i - low_bound_i;
  end

  assign full   = (state_q == FR_WARM) || q_status_i.full;
  assign accept = push && !full;

  // Next state: load seeds and warm up on restart, advance and queue on draw
  always_comb begin
    state_d  = state_q;
    word_a_d = word_a_q;
    word_b_d = word_b_q;
    cnt_d    = cnt_q;
    q_push_o = 1'b0;
    q_job_o  = '{sum: sum, lo: low_bound_i, span: span, zero: (span == '0)};
    case (state_q)
      FR_IDLE: begin
        if (accept && (command_i == CMD_RESTART)) begin
          word_a_d = first_seed_q;
          word_b_d = second_seed_q;
          cnt_d    = warmup_q;
          if (warmup_q != '0) begin
            state_d = FR_WARM;
          end
        end else if (accept) begin
          word_a_d = word_b_q;
          word_b_d = next_b;
          q_push_o = 1'b1;
        end
      end
      FR_WARM: begin
        word_a_d = word_b_q;
        word_b_d = next_b;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == WarmW'(1)) begin
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FR_IDLE;
      word_a_q <= '0;
      word_b_q <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      word_a_q <= word_a_d;
      word_b_q <= word_b_d;
      cnt_q    <= cnt_d;
    end
  end

  // A restart with warm-up steps enters the warm-up loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_RESTART && warmup_q != '0) |=> (state_q == FR_WARM))
    else $error("restart did not start warm-up");

  // Warm-up never runs with a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FR_WARM) |-> (cnt_q != '0))
    else $error("warm-up counter underflow");

  // Nothing is queued during warm-up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FR_WARM) |-> !q_push_o)
    else $error("draw queued during warm-up");

endmodule

FILE: rtl/xrd_queue.sv
// Short queue of draw jobs between the front and back parts.
module xrd_queue
  import xrd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      job_i,
  input  logic      pop_i,
  output job_t      job_o,
  output q_status_t status_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == QCntW'(QDepth));
  assign status_o.valid = (cnt_q != '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && status_o.valid;
  assign job_o   = mem_q[rptr_q];

  // Store a pushed beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Fill count stays within depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue overflow");

  // The front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push while full");

  // The back never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> status_o.valid)
    else $error("pop while empty");

endmodule

FILE: rtl/xrd_back.sv
// Back part: radix-2 remainder unit, offset add and result register.
module xrd_back
  import xrd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  job_t                    job_i,
  input  q_status_t               q_status_i,
  output logic                    q_pop_o,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [WordW-1:0] value_o,
  output logic [WordW-1:0]        raw_sum_o,
  output logic                    span_zero_o
);

  back_state_e state_q, state_d;
  logic [WordW-1:0]   rem_q, rem_d;
  logic [WordW-1:0]   dvd_q, dvd_d;
  logic [WordW-1:0]   span_q, sum_q, lo_q;
  logic               zero_q;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               load_job, load_out, out_free;
  logic               out_valid_q;
  logic [WordW-1:0]   val_q, raw_q;
  logic               zflag_q;
  logic [WordW:0]     trial, diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, dvd_q[WordW-1]};
    diff  = trial - {1'b0, span_q};
  end

  assign out_free = !out_valid_q || pop;

  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    dvd_d    = dvd_q;
    cnt_d    = cnt_q;
    load_job = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_status_i.valid) begin
          load_job = 1'b1;
          rem_d    = '0;
          dvd_d    = job_i.sum;
          cnt_d    = '0;
          state_d  = job_i.zero ? BK_DONE : BK_DIV;
        end
      end
      BK_DIV: begin
        rem_d = diff[WordW] ? trial[WordW-1:0] : diff[WordW-1:0];
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(WordW - 1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign q_pop_o = load_job;

  // Hold the job operands and remainder
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    if (load_job) begin
      span_q <= job_i.span;
      sum_q  <= job_i.sum;
      lo_q   <= job_i.lo;
      zero_q <= job_i.zero;
    end
    if (load_out) begin
      val_q   <= zero_q ? '0 : rem_q + lo_q;
      raw_q   <= sum_q;
      zflag_q <= zero_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty       = !out_valid_q;
  assign value_o     = val_q;
  assign raw_sum_o   = raw_q;
  assign span_zero_o = zflag_q;

  // A waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> ($stable(val_q) && $stable(raw_q) && out_valid_q))
    else $error("waiting result overwritten");

  // The divider runs its full count before finishing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV && cnt_q != DivCntW'(WordW - 1)) |=> (state_q == BK_DIV))
    else $error("divider left early");

  // Remainder stays below the divisor while dividing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (rem_q < span_q))
    else $error("remainder out of range");

endmodule

FILE: rtl/xorshift128plus_ranged_draw.sv
// Top level of the xorshift128+ ranged draw block.
//
// Input channel (push/full): each beat is a command with two bounds. A draw
// (command 0) advances the xorshift128+ generator once and yields one result;
// a restart (command 1) loads both state words from the seed registers and
// runs warmup_steps advances, yielding nothing. The front takes a draw
// whenever full is low; a restart keeps full high until its warm-up is done.
// Result channel (empty/pop): value = (raw_sum mod span) + low_bound, where
// span = high_bound - low_bound wrapped; a zero span gives value 0 and sets
// span_zero. Each draw passes through the radix-2 remainder unit (a zero
// span skips the division), which holds one job at a time: the back pops
// the next job only after the last result has entered the result register.
// A two-entry queue lets the front keep accepting while the back divides.
// Reset clears the state words to zero, the seeds to 1 and 2 and the warm-up
// count to 10. When the receiver stalls, the result register holds, the back
// waits, the queue fills, and then full stays high.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 first
// seed, 1 second seed, 2 warm-up steps); the user must write it only while
// the block is idle, which the block itself does not enforce.
module xorshift128plus_ranged_draw
  import xrd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [WordW-1:0]        cfg_data_i,
  input  logic                    push,
  output logic                    full,
  input  logic                    command_i,
  input  logic signed [WordW-1:0] low_bound_i,
  input  logic signed [WordW-1:0] high_bound_i,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [WordW-1:0] value_o,
  output logic [WordW-1:0]        raw_sum_o,
  output logic                    span_zero_o
);

  q_status_t q_status;
  logic      q_push, q_pop;
  job_t      job_in, job_out;

  xrd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .low_bound_i  (low_bound_i),
    .high_bound_i (high_bound_i),
    .q_status_i   (q_status),
    .q_push_o     (q_push),
    .q_job_o      (job_in)
  );

  xrd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .job_i    (job_in),
    .pop_i    (q_pop),
    .job_o    (job_out),
    .status_o (q_status)
  );

  xrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .q_status_i  (q_status),
    .q_pop_o     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .value_o     (value_o),
    .raw_sum_o   (raw_sum_o),
    .span_zero_o (span_zero_o)
  );

endmodule
